// ----- rtl/pid_position_controller_macros.svh -----
// ----------------------------------------------------------------------------
// pid position controller assertion macros
// clocked assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_CONTROLLER_MACROS_SVH
`define PID_POSITION_CONTROLLER_MACROS_SVH

// property checked on every rising edge, quiet while reset is high
`define PIDPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PIDPC_ASSERT_NEXT(label, ante, cons, msg) \
  `PIDPC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/pidpc_pkg.sv -----
// ----------------------------------------------------------------------------
// pidpc_pkg
// register map, pipeline depth and fixed arithmetic constants
// ----------------------------------------------------------------------------
package pidpc_pkg;

  // apb address width: eight 32-bit registers
  localparam int ADDR_WIDTH = 5;

  // register map, word index
  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_CENTER_OFFSET  = 3'd3,
    REG_INTEGRAL_UPPER = 3'd4,
    REG_INTEGRAL_LOWER = 3'd5,
    REG_PULSE_UPPER    = 3'd6,
    REG_PULSE_LOWER    = 3'd7
  } reg_index_t;

  // number of register stages from input register to result register
  localparam int NUM_STAGES = 7;

  // center pulse value and the fixed scale of the 0.1 s time base
  localparam int CENTER_PULSE = 1500;
  localparam int TIME_SCALE   = 10;

  // width of the exact fixed point sum of all terms
  localparam int TOTAL_WIDTH = 41;

  // quotient by ten: saturated 17-bit input times reciprocal, shifted down
  localparam int                 QIN_WIDTH   = 17;
  localparam int                 RECIP_WIDTH = 20;
  localparam logic [19:0]        RECIP_DIV10 = 20'd838861;
  localparam int                 RECIP_SHIFT = 23;
  localparam int                 QUOT_WIDTH  = 14;

endpackage

// ----- rtl/pid_position_controller.sv -----
// ----------------------------------------------------------------------------
// pid_position_controller
// pid position loop with saturating error sum, integral clamp and pulse clamp
// ----------------------------------------------------------------------------
// Takes one error sample per transfer and returns one clamped pulse value per
// sample. A new sample is accepted every clock cycle unless a stalled result
// holds the pipeline; the result appears seven register stages later, through
// accumulator update, integral multiply, integral clamp, term sum, divide by
// ten, pulse clamp. The error sum update is the only feedback path. Gains are
// signed Q(15-F).F, F being GAIN_FRAC_BITS. The user writes registers over apb
// only while no sample is in flight; the block itself does not enforce this.
module pid_position_controller #(
  parameter int SUM_WIDTH      = 32,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // [15:0] error_now, [31:16] error_before
  input  logic                            s_tuser,   // [0] clear_sum
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // [11:0] drive_pulse, [15:12] zero
  output logic [1:0]                      m_tuser,   // [0] integral_clamped, [1] output_clamped
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pidpc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import pidpc_pkg::*;

  localparam int IW = SUM_WIDTH + 16;
  localparam int TW = TOTAL_WIDTH;
  localparam int QS = QUOT_WIDTH + 1;
  localparam logic signed [IW-1:0] DEN_I   = IW'(TIME_SCALE << GAIN_FRAC_BITS);
  localparam logic signed [TW-1:0] DEN_T   = TW'(TIME_SCALE << GAIN_FRAC_BITS);
  localparam logic signed [TW-1:0] TEN     = TW'(TIME_SCALE);
  localparam logic signed [TW-1:0] HUNDRED = TW'(TIME_SCALE * TIME_SCALE);
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  // configuration registers
  logic signed [15:0] gain_p, gain_i, gain_d;
  logic signed [10:0] center_offset;
  logic signed [15:0] integral_upper, integral_lower;
  logic        [11:0] pulse_upper, pulse_lower;
  logic               cfg_write;
  reg_index_t         cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[ADDR_WIDTH-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      center_offset  <= '0;
      integral_upper <= 16'sd200;
      integral_lower <= -16'sd200;
      pulse_upper    <= 12'd2000;
      pulse_lower    <= 12'd1000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_P:         gain_p         <= pwdata[15:0];
        REG_GAIN_I:         gain_i         <= pwdata[15:0];
        REG_GAIN_D:         gain_d         <= pwdata[15:0];
        REG_CENTER_OFFSET:  center_offset  <= pwdata[10:0];
        REG_INTEGRAL_UPPER: integral_upper <= pwdata[15:0];
        REG_INTEGRAL_LOWER: integral_lower <= pwdata[15:0];
        REG_PULSE_UPPER:    pulse_upper    <= pwdata[11:0];
        REG_PULSE_LOWER:    pulse_lower    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // register reads, signed fields sign extended
  always_comb begin
    case (cfg_index)
      REG_GAIN_P:         prdata = 32'(gain_p);
      REG_GAIN_I:         prdata = 32'(gain_i);
      REG_GAIN_D:         prdata = 32'(gain_d);
      REG_CENTER_OFFSET:  prdata = 32'(center_offset);
      REG_INTEGRAL_UPPER: prdata = 32'(integral_upper);
      REG_INTEGRAL_LOWER: prdata = 32'(integral_lower);
      REG_PULSE_UPPER:    prdata = 32'(pulse_upper);
      REG_PULSE_LOWER:    prdata = 32'(pulse_lower);
      default:            prdata = '0;
    endcase
  end

  // pipeline flow control: a stage loads when empty or when it drains
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] load;
  logic [NUM_STAGES-1:0] valid_in;

  always_comb begin
    load[NUM_STAGES-1] = !valid[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid[k] || load[k+1];
    end
  end

  assign valid_in = {valid[NUM_STAGES-2:0], s_tvalid};
  assign s_tready = load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= (valid & ~load) | (valid_in & load);
    end
  end

  // stage 0: input register
  logic signed [15:0] e0, eb0;
  logic               clr0;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      e0   <= s_tdata[15:0];
      eb0  <= s_tdata[31:16];
      clr0 <= s_tuser;
    end
  end

  // stage 1: saturating error sum, proportional and derivative products
  logic signed [SUM_WIDTH-1:0] error_sum, error_sum_next;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic signed [16:0]          diff;
  logic signed [SUM_WIDTH-1:0] s1;
  logic signed [31:0]          pe1;
  logic signed [32:0]          de1;

  always_comb begin
    sum_wide = {error_sum[SUM_WIDTH-1], error_sum} + (SUM_WIDTH+1)'(e0);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
    error_sum_next = clr0 ? '0 : sum_sat;
    diff = 17'(e0) - 17'(eb0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
    end else if (valid[0] && load[1]) begin
      error_sum <= error_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s1  <= sum_sat;
      pe1 <= 32'(gain_p) * 32'(e0);
      de1 <= 33'(gain_d) * 33'(diff);
    end
  end

  // stage 2: integral product
  logic signed [IW-1:0] ie2;
  logic signed [31:0]   pe2;
  logic signed [32:0]   de2;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      ie2 <= IW'(gain_i) * IW'(s1);
      pe2 <= pe1;
      de2 <= de1;
    end
  end

  // stage 3: integral clamp, upper limit tested first; other terms summed
  logic signed [IW-1:0] ilim_hi, ilim_lo;
  logic signed [TW-1:0] it_sel;
  logic                 ic_sel;
  logic signed [TW-1:0] base;
  logic signed [TW-1:0] it3, part3;
  logic                 ic3;

  always_comb begin
    ilim_hi = IW'(integral_upper) * DEN_I;
    ilim_lo = IW'(integral_lower) * DEN_I;
    if (ie2 > ilim_hi) begin
      it_sel = TW'(ilim_hi);
      ic_sel = 1'b1;
    end else if (ie2 < ilim_lo) begin
      it_sel = TW'(ilim_lo);
      ic_sel = 1'b1;
    end else begin
      it_sel = TW'(ie2);
      ic_sel = 1'b0;
    end
    base = TW'(CENTER_PULSE + center_offset) * DEN_T;
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      it3   <= it_sel;
      ic3   <= ic_sel;
      part3 <= base + TW'(pe2) * TEN + TW'(de2) * HUNDRED;
    end
  end

  // stage 4: total, magnitude, drop fraction bits, saturate for the divide
  logic signed [TW-1:0]  total;
  logic        [TW-1:0]  mag, mag_sh;
  logic [QIN_WIDTH-1:0]  u4;
  logic                  neg4, ic4;

  always_comb begin
    total  = part3 + it3;
    mag    = total[TW-1] ? TW'(-total) : TW'(total);
    mag_sh = mag >> GAIN_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      neg4 <= total[TW-1];
      ic4  <= ic3;
      u4   <= (mag_sh[TW-1:QIN_WIDTH] != '0) ? '1 : mag_sh[QIN_WIDTH-1:0];
    end
  end

  // stage 5: divide by ten through reciprocal multiply
  logic [QIN_WIDTH+RECIP_WIDTH-1:0] quot_prod;
  logic [QUOT_WIDTH-1:0]            q5;
  logic                             neg5, ic5;

  assign quot_prod = (QIN_WIDTH+RECIP_WIDTH)'(u4) * (QIN_WIDTH+RECIP_WIDTH)'(RECIP_DIV10);

  always_ff @(posedge clk) begin
    if (load[5]) begin
      q5   <= quot_prod[RECIP_SHIFT +: QUOT_WIDTH];
      neg5 <= neg4;
      ic5  <= ic4;
    end
  end

  // stage 6: signed quotient, pulse clamp, result register
  logic signed [QS-1:0] qs, pu_s, pl_s;
  logic        [11:0]   pulse_sel;
  logic                 oc_sel;
  logic        [11:0]   drive_pulse;
  logic                 integral_clamped, output_clamped;

  always_comb begin
    qs   = neg5 ? -QS'(q5) : QS'(q5);
    pu_s = QS'(pulse_upper);
    pl_s = QS'(pulse_lower);
    if (qs > pu_s) begin
      pulse_sel = pulse_upper;
      oc_sel    = 1'b1;
    end else if (qs < pl_s) begin
      pulse_sel = pulse_lower;
      oc_sel    = 1'b1;
    end else begin
      pulse_sel = qs[11:0];
      oc_sel    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      drive_pulse      <= pulse_sel;
      output_clamped   <= oc_sel;
      integral_clamped <= ic5;
    end
  end

  // result transfer
  assign m_tvalid = valid[NUM_STAGES-1];
  assign m_tdata  = {4'b0000, drive_pulse};
  assign m_tuser  = {output_clamped, integral_clamped};

endmodule

// ----- rtl/pidpc_checker.sv -----
// ----------------------------------------------------------------------------
// pidpc_checker
// port level checks of the pid position controller stream behavior
// ----------------------------------------------------------------------------
`include "pid_position_controller_macros.svh"

module pidpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import pidpc_pkg::*;

  localparam int CW = $clog2(NUM_STAGES + 2);

  // samples accepted whose result transfer is still pending
  logic [CW-1:0] outstanding;
  logic          in_xfer, out_xfer;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_xfer && !out_xfer) begin
      outstanding <= outstanding + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  // a stalled result stays offered and unchanged
  `PIDPC_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result valid dropped")
  `PIDPC_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  // every result has a sample behind it
  `PIDPC_ASSERT(a_no_orphan, m_tvalid |-> outstanding != '0, "result without a sample")
  // never more samples in flight than pipeline stages
  `PIDPC_ASSERT(a_depth, outstanding <= CW'(NUM_STAGES), "more samples in flight than stages")
  // empty pipeline takes a sample right after reset
  `PIDPC_ASSERT(a_ready_after_reset, $fell(rst) |-> s_tready, "not ready after reset")

endmodule

bind pid_position_controller pidpc_checker u_pidpc_checker (.*);
